@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define WSVE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked in the cycle after the antecedent, outside reset.
`define WSVE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/wsve_pkg.sv @@
`timescale 1ns / 1ps

package wsve_pkg;

   localparam int MAX_WINDOW = 64;
   localparam int ADDR_W     = $clog2(MAX_WINDOW);
   localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
   localparam int WLEN_W     = 7;
   localparam int FRAME_W    = 32;
   localparam int TIME_W     = 63;
   localparam int POS_W      = 32;
   localparam int PERIOD_W   = 46;
   localparam int PERIOD_FW  = 16;
   localparam int SCALE_BITS = 22;
   localparam int SHIFT_W    = $clog2(TIME_W - SCALE_BITS + 1);
   localparam int ENTRY_W    = TIME_W + 3 * POS_W;

   // accumulator widths
   localparam int SU_W  = SCALE_BITS + ADDR_W;
   localparam int SUU_W = 2 * SCALE_BITS + ADDR_W;
   localparam int SP_W  = POS_W + ADDR_W;
   localparam int SUP_W = POS_W + SCALE_BITS + ADDR_W;

   // shared multiplier
   localparam int NS_W  = 30;
   localparam int MA_W  = SP_W;
   localparam int MB_W  = (SU_W + 1 > NS_W + 1) ? SU_W + 1 : NS_W + 1;
   localparam int P_W   = MA_W + MB_W;
   localparam int W_W   = SUP_W + CNT_W + 1;
   localparam int D_W   = ((W_W > P_W) ? W_W : P_W) + 1;

   localparam int DEN_W   = 2 * SCALE_BITS + 2 * ADDR_W;
   localparam int MAG_W   = SUP_W + ADDR_W;
   localparam int CHUNKS  = 3;
   localparam int CHUNK_W = (MAG_W + CHUNKS - 1) / CHUNKS;
   localparam int M_W     = MAG_W + NS_W;
   localparam int DD_W    = DEN_W + TIME_W - SCALE_BITS;
   localparam int Q_W     = 33;
   localparam int VEL_W   = 32;

   localparam logic [NS_W-1:0] NS_PER_S = NS_W'(1000000000);

   typedef enum logic [1:0] {
      CSR_ENABLE,
      CSR_WLEN,
      CSR_MAX_GAP,
      CSR_PERIOD
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHECK,
      ST_TMUL1,
      ST_TMUL2,
      ST_STORE,
      ST_SCAN,
      ST_SHIFT,
      ST_ACC_RD,
      ST_ACC_U,
      ST_ACC_M,
      ST_DEN1,
      ST_DEN2,
      ST_NUM1,
      ST_NUM2,
      ST_SCLM,
      ST_SCLA,
      ST_DIV,
      ST_DWAIT,
      ST_EMIT
   } state_type;

endpackage

@@ rtl/core/window_slope_velocity_estimator.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// req_      in         frame_number, stamp_ns, pos_x, pos_y, pos_z
// rsp_      out        vel_x, vel_y, vel_z, out_stamp_ns
// csr_      in         index, data (register write)
//
// One sample at a time. A fit uses one history read port, one shared
// multiplier and a bit-serial divider that runs once per axis; the time
// scale shift is up to 41.
// Reset (synchronous) empties the history and restores register defaults.
// A finished result waits in the output register; the next sample is taken
// meanwhile, and only a second result stalls on rsp_ready.

module window_slope_velocity_estimator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [wsve_pkg::FRAME_W-1:0]         req_frame_number,
   input  logic [wsve_pkg::TIME_W-1:0]          req_stamp_ns,
   input  logic signed [wsve_pkg::POS_W-1:0]    req_pos_x,
   input  logic signed [wsve_pkg::POS_W-1:0]    req_pos_y,
   input  logic signed [wsve_pkg::POS_W-1:0]    req_pos_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [wsve_pkg::VEL_W-1:0]    rsp_vel_x,
   output logic signed [wsve_pkg::VEL_W-1:0]    rsp_vel_y,
   output logic signed [wsve_pkg::VEL_W-1:0]    rsp_vel_z,
   output logic [wsve_pkg::TIME_W-1:0]          rsp_out_stamp_ns,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [1:0]                           csr_index,
   input  logic [wsve_pkg::PERIOD_W-1:0]        csr_data
);

   localparam int ADDR_W  = wsve_pkg::ADDR_W;
   localparam int CNT_W   = wsve_pkg::CNT_W;
   localparam int TIME_W  = wsve_pkg::TIME_W;
   localparam int POS_W   = wsve_pkg::POS_W;
   localparam int MA_W    = wsve_pkg::MA_W;
   localparam int MB_W    = wsve_pkg::MB_W;
   localparam int P_W     = wsve_pkg::P_W;
   localparam int W_W     = wsve_pkg::W_W;
   localparam int D_W     = wsve_pkg::D_W;
   localparam int SB      = wsve_pkg::SCALE_BITS;

   // ---------------- state machine
   wsve_pkg::state_type state_ff, state_in;

   // ---------------- configuration registers
   logic                              en_ff;
   logic [wsve_pkg::WLEN_W-1:0]       wlen_ff;
   logic [wsve_pkg::FRAME_W-1:0]      gap_ff;
   logic [wsve_pkg::PERIOD_W-1:0]     period_ff;

   // ---------------- sample being worked on
   logic [wsve_pkg::FRAME_W-1:0]      frame_ff;
   logic [TIME_W-1:0]                 stamp_ff;
   logic [POS_W-1:0]                  pos_ff [3];
   logic [TIME_W-1:0]                 t_ff;

   // ---------------- window bookkeeping
   logic [wsve_pkg::FRAME_W-1:0]      prev_frame_ff;
   logic                              prev_valid_ff;
   logic [CNT_W-1:0]                  count_ff;
   logic [ADDR_W-1:0]                 oldest_ff;

   // ---------------- history memory
   logic [wsve_pkg::ENTRY_W-1:0]      hist_mem [wsve_pkg::MAX_WINDOW];
   logic [wsve_pkg::ENTRY_W-1:0]      rd_data_ff;
   logic                              mem_we;
   logic                              mem_re;
   logic [ADDR_W-1:0]                 mem_waddr;
   logic [ADDR_W-1:0]                 mem_raddr;
   logic [TIME_W-1:0]                 rd_t;
   logic [POS_W-1:0]                  rd_p [3];

   // ---------------- fit datapath
   logic [CNT_W-1:0]                  k_ff;
   logic                              rdv_ff;
   logic [TIME_W-1:0]                 tmin_ff;
   logic [TIME_W-1:0]                 tmax_ff;
   logic [TIME_W-1:0]                 dsh_ff;
   logic [wsve_pkg::SHIFT_W-1:0]      s_ff;
   logic [SB-1:0]                     u_ff;
   logic [2:0]                        j_ff;
   logic                              pv_ff;
   logic [1:0]                        pj_ff;
   logic [wsve_pkg::SU_W-1:0]         su_ff;
   logic [wsve_pkg::SUU_W-1:0]        suu_ff;
   logic signed [wsve_pkg::SP_W-1:0]  sp_ff [3];
   logic signed [wsve_pkg::SUP_W-1:0] sup_ff [3];
   logic signed [P_W-1:0]             prod_ff;
   logic signed [W_W-1:0]             wide_ff;
   logic [wsve_pkg::DEN_W-1:0]        den_ff;
   logic [1:0]                        axis_ff;
   logic                              neg_ff;
   logic [wsve_pkg::MAG_W-1:0]        mag_ff;
   logic [wsve_pkg::M_W-1:0]          m_ff;
   logic [1:0]                        c_ff;
   logic [wsve_pkg::VEL_W-1:0]        vel_ff [3];

   // ---------------- output register
   logic                              rsp_valid_ff;
   logic [wsve_pkg::VEL_W-1:0]        rsp_vel_ff [3];
   logic [TIME_W-1:0]                 rsp_stamp_ff;

   // ---------------- combinational helpers
   logic                              drop;
   logic                              gap_clear;
   logic [CNT_W-1:0]                  win;
   logic [CNT_W-1:0]                  cnt_keep;
   logic [ADDR_W-1:0]                 old_keep;
   logic                              scan_issue;
   logic                              scan_end;
   logic                              shift_more;
   logic [TIME_W-1:0]                 t_rel;
   logic [TIME_W-1:0]                 t_rel_sh;
   logic signed [MA_W-1:0]            mul_a;
   logic signed [MB_W-1:0]            mul_b;
   logic signed [wsve_pkg::SUP_W-1:0] nmul_x;
   logic signed [D_W-1:0]             diff;
   logic [D_W-1:0]                    diff_abs;
   logic [wsve_pkg::CHUNK_W-1:0]      chunk;
   logic                              div_start;
   logic                              div_done;
   logic [wsve_pkg::Q_W-1:0]          div_q;
   logic [wsve_pkg::Q_W-1:0]          lim;
   logic [wsve_pkg::Q_W-1:0]          q_sat;
   logic [wsve_pkg::VEL_W-1:0]        vel_now;
   logic                              out_free;

   assign rd_t    = rd_data_ff[wsve_pkg::ENTRY_W-1 -: TIME_W];
   assign rd_p[0] = rd_data_ff[0 +: POS_W];
   assign rd_p[1] = rd_data_ff[POS_W +: POS_W];
   assign rd_p[2] = rd_data_ff[2*POS_W +: POS_W];

   // Drop repeats and disabled samples; clear history on a large frame advance.
   assign drop      = !en_ff || (prev_valid_ff && frame_ff == prev_frame_ff);
   assign gap_clear = prev_valid_ff && ((frame_ff - prev_frame_ff) > gap_ff);

   // Window clamp and trim of the oldest samples before the store.
   always_comb begin
      win      = (wlen_ff > wsve_pkg::WLEN_W'(wsve_pkg::MAX_WINDOW))
                 ? CNT_W'(wsve_pkg::MAX_WINDOW) : CNT_W'(wlen_ff);
      cnt_keep = count_ff;
      old_keep = oldest_ff;
      if (win != '0 && count_ff >= win) begin
         old_keep = oldest_ff + ADDR_W'(count_ff - win + 1'b1);
         cnt_keep = win - 1'b1;
      end
   end

   assign mem_waddr  = old_keep + cnt_keep[ADDR_W-1:0];
   assign scan_issue = k_ff != count_ff;
   assign scan_end   = !scan_issue && !rdv_ff;
   assign shift_more = dsh_ff[TIME_W-1:SB] != '0;
   assign t_rel      = rd_t - tmin_ff;
   assign t_rel_sh   = t_rel >> s_ff;

   assign diff     = D_W'(wide_ff) - D_W'(prod_ff);
   assign diff_abs = diff[D_W-1] ? D_W'(-diff) : D_W'(diff);
   assign chunk    = mag_ff[c_ff * wsve_pkg::CHUNK_W +: wsve_pkg::CHUNK_W];

   // Shared multiplier operands.
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      nmul_x = '0;
      case (state_ff)
         wsve_pkg::ST_ACC_M: begin
            if (j_ff == 3'd0) begin
               mul_a = MA_W'(u_ff);
            end else begin
               mul_a = MA_W'($signed(rd_p[j_ff[1:0] - 2'd1]));
            end
            mul_b = MB_W'(u_ff);
         end
         wsve_pkg::ST_DEN1: begin
            mul_a  = MA_W'(su_ff);
            mul_b  = MB_W'(su_ff);
            nmul_x = wsve_pkg::SUP_W'(suu_ff);
         end
         wsve_pkg::ST_NUM1: begin
            mul_a  = sp_ff[axis_ff];
            mul_b  = MB_W'(su_ff);
            nmul_x = sup_ff[axis_ff];
         end
         wsve_pkg::ST_SCLM: begin
            mul_a = MA_W'(chunk);
            mul_b = MB_W'(wsve_pkg::NS_PER_S);
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // Saturate and sign the quotient.
   always_comb begin
      lim     = neg_ff ? wsve_pkg::Q_W'(33'h080000000) : wsve_pkg::Q_W'(33'h07FFFFFFF);
      q_sat   = (div_q > lim) ? lim : div_q;
      vel_now = neg_ff ? wsve_pkg::VEL_W'(-q_sat) : q_sat[wsve_pkg::VEL_W-1:0];
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // ---------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wsve_pkg::ST_IDLE:   if (req_valid) state_in = wsve_pkg::ST_CHECK;
         wsve_pkg::ST_CHECK: begin
            if (drop) begin
               state_in = wsve_pkg::ST_IDLE;
            end else if (period_ff != '0) begin
               state_in = wsve_pkg::ST_TMUL1;
            end else begin
               state_in = wsve_pkg::ST_STORE;
            end
         end
         wsve_pkg::ST_TMUL1:  state_in = wsve_pkg::ST_TMUL2;
         wsve_pkg::ST_TMUL2:  state_in = wsve_pkg::ST_STORE;
         wsve_pkg::ST_STORE: begin
            if (win == '0 || cnt_keep == '0) begin
               state_in = wsve_pkg::ST_IDLE;
            end else begin
               state_in = wsve_pkg::ST_SCAN;
            end
         end
         wsve_pkg::ST_SCAN:   if (scan_end) state_in = wsve_pkg::ST_SHIFT;
         wsve_pkg::ST_SHIFT:  if (!shift_more) state_in = wsve_pkg::ST_ACC_RD;
         wsve_pkg::ST_ACC_RD: begin
            if (k_ff == count_ff) begin
               state_in = wsve_pkg::ST_DEN1;
            end else begin
               state_in = wsve_pkg::ST_ACC_U;
            end
         end
         wsve_pkg::ST_ACC_U:  state_in = wsve_pkg::ST_ACC_M;
         wsve_pkg::ST_ACC_M:  if (j_ff == 3'd4) state_in = wsve_pkg::ST_ACC_RD;
         wsve_pkg::ST_DEN1:   state_in = wsve_pkg::ST_DEN2;
         wsve_pkg::ST_DEN2: begin
            if (diff == '0) begin
               state_in = wsve_pkg::ST_IDLE;
            end else begin
               state_in = wsve_pkg::ST_NUM1;
            end
         end
         wsve_pkg::ST_NUM1:   state_in = wsve_pkg::ST_NUM2;
         wsve_pkg::ST_NUM2:   state_in = wsve_pkg::ST_SCLM;
         wsve_pkg::ST_SCLM:   state_in = wsve_pkg::ST_SCLA;
         wsve_pkg::ST_SCLA: begin
            if (c_ff == 2'(wsve_pkg::CHUNKS - 1)) begin
               state_in = wsve_pkg::ST_DIV;
            end else begin
               state_in = wsve_pkg::ST_SCLM;
            end
         end
         wsve_pkg::ST_DIV:    state_in = wsve_pkg::ST_DWAIT;
         wsve_pkg::ST_DWAIT: begin
            if (div_done) begin
               state_in = (axis_ff == 2'd2) ? wsve_pkg::ST_EMIT : wsve_pkg::ST_NUM1;
            end
         end
         wsve_pkg::ST_EMIT:   if (out_free) state_in = wsve_pkg::ST_IDLE;
         default:             state_in = wsve_pkg::ST_IDLE;
      endcase
   end

   // ---------------- state outputs
   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_raddr = oldest_ff + k_ff[ADDR_W-1:0];
      div_start = 1'b0;
      unique case (state_ff)
         wsve_pkg::ST_IDLE:   req_ready = 1'b1;
         wsve_pkg::ST_STORE:  mem_we    = win != '0;
         wsve_pkg::ST_SCAN:   mem_re    = scan_issue;
         wsve_pkg::ST_ACC_RD: mem_re    = k_ff != count_ff;
         wsve_pkg::ST_DIV:    div_start = 1'b1;
         default:             req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wsve_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff     <= 1'b0;
         wlen_ff   <= wsve_pkg::WLEN_W'(5);
         gap_ff    <= wsve_pkg::FRAME_W'(10);
         period_ff <= '0;
      end else if (csr_valid) begin
         unique case (wsve_pkg::csr_index_type'(csr_index))
            wsve_pkg::CSR_ENABLE:  en_ff     <= csr_data[0];
            wsve_pkg::CSR_WLEN:    wlen_ff   <= csr_data[wsve_pkg::WLEN_W-1:0];
            wsve_pkg::CSR_MAX_GAP: gap_ff    <= csr_data[wsve_pkg::FRAME_W-1:0];
            wsve_pkg::CSR_PERIOD:  period_ff <= csr_data;
            default:               en_ff     <= en_ff;
         endcase
      end
   end

   // ---------------- history memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_waddr] <= {t_ff, pos_ff[2], pos_ff[1], pos_ff[0]};
      end
      if (mem_re) begin
         rd_data_ff <= hist_mem[mem_raddr];
      end
   end

   // ---------------- window control state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_frame_ff <= '0;
         prev_valid_ff <= 1'b0;
         count_ff      <= '0;
         oldest_ff     <= '0;
         rdv_ff        <= 1'b0;
         pv_ff         <= 1'b0;
      end else begin
         rdv_ff <= 1'b0;
         pv_ff  <= 1'b0;
         case (state_ff)
            wsve_pkg::ST_CHECK: begin
               if (!drop) begin
                  prev_frame_ff <= frame_ff;
                  prev_valid_ff <= 1'b1;
                  if (gap_clear) begin
                     count_ff  <= '0;
                     oldest_ff <= '0;
                  end
               end
            end
            wsve_pkg::ST_STORE: begin
               if (win == '0) begin
                  count_ff  <= '0;
                  oldest_ff <= '0;
               end else begin
                  count_ff  <= cnt_keep + 1'b1;
                  oldest_ff <= old_keep;
               end
            end
            wsve_pkg::ST_SCAN:  rdv_ff <= scan_issue;
            wsve_pkg::ST_ACC_M: pv_ff  <= j_ff != 3'd4;
            default:            rdv_ff <= 1'b0;
         endcase
      end
   end

   // ---------------- fit datapath
   always_ff @(posedge clock) begin
      // fold the previous product into its sum
      if (pv_ff) begin
         if (pj_ff == 2'd0) begin
            suu_ff <= suu_ff + prod_ff[wsve_pkg::SUU_W-1:0];
         end else begin
            sup_ff[pj_ff - 2'd1] <= sup_ff[pj_ff - 2'd1] + prod_ff[wsve_pkg::SUP_W-1:0];
         end
      end
      case (state_ff)
         wsve_pkg::ST_IDLE: begin
            frame_ff  <= req_frame_number;
            stamp_ff  <= req_stamp_ns;
            pos_ff[0] <= req_pos_x;
            pos_ff[1] <= req_pos_y;
            pos_ff[2] <= req_pos_z;
         end
         wsve_pkg::ST_CHECK: begin
            t_ff <= stamp_ff;
         end
         wsve_pkg::ST_TMUL1: begin
            t_ff <= TIME_W'(frame_ff * period_ff[wsve_pkg::PERIOD_W-1:wsve_pkg::PERIOD_FW]);
         end
         wsve_pkg::ST_TMUL2: begin
            t_ff <= t_ff + TIME_W'((frame_ff * period_ff[wsve_pkg::PERIOD_FW-1:0])
                                   >> wsve_pkg::PERIOD_FW);
         end
         wsve_pkg::ST_STORE: begin
            k_ff    <= '0;
            tmin_ff <= '1;
            tmax_ff <= '0;
         end
         wsve_pkg::ST_SCAN: begin
            if (scan_issue) begin
               k_ff <= k_ff + 1'b1;
            end
            if (rdv_ff) begin
               if (rd_t < tmin_ff) tmin_ff <= rd_t;
               if (rd_t > tmax_ff) tmax_ff <= rd_t;
            end
            if (scan_end) begin
               dsh_ff <= tmax_ff - tmin_ff;
               s_ff   <= '0;
            end
         end
         wsve_pkg::ST_SHIFT: begin
            // narrow the time span below the scale width
            if (shift_more) begin
               dsh_ff <= dsh_ff >> 1;
               s_ff   <= s_ff + 1'b1;
            end else begin
               k_ff      <= '0;
               su_ff     <= '0;
               suu_ff    <= '0;
               sp_ff[0]  <= '0;
               sp_ff[1]  <= '0;
               sp_ff[2]  <= '0;
               sup_ff[0] <= '0;
               sup_ff[1] <= '0;
               sup_ff[2] <= '0;
            end
         end
         wsve_pkg::ST_ACC_RD: begin
            if (k_ff != count_ff) begin
               k_ff <= k_ff + 1'b1;
            end
         end
         wsve_pkg::ST_ACC_U: begin
            u_ff     <= t_rel_sh[SB-1:0];
            su_ff    <= su_ff + wsve_pkg::SU_W'(t_rel_sh[SB-1:0]);
            sp_ff[0] <= sp_ff[0] + wsve_pkg::SP_W'($signed(rd_p[0]));
            sp_ff[1] <= sp_ff[1] + wsve_pkg::SP_W'($signed(rd_p[1]));
            sp_ff[2] <= sp_ff[2] + wsve_pkg::SP_W'($signed(rd_p[2]));
            j_ff     <= '0;
         end
         wsve_pkg::ST_ACC_M: begin
            if (j_ff != 3'd4) begin
               prod_ff <= P_W'(mul_a) * P_W'(mul_b);
               pj_ff   <= j_ff[1:0];
               j_ff    <= j_ff + 1'b1;
            end
         end
         wsve_pkg::ST_DEN1: begin
            prod_ff <= P_W'(mul_a) * P_W'(mul_b);
            wide_ff <= W_W'($signed({1'b0, count_ff})) * W_W'(nmul_x);
         end
         wsve_pkg::ST_DEN2: begin
            den_ff  <= diff[wsve_pkg::DEN_W-1:0];
            axis_ff <= '0;
         end
         wsve_pkg::ST_NUM1: begin
            prod_ff <= P_W'(mul_a) * P_W'(mul_b);
            wide_ff <= W_W'($signed({1'b0, count_ff})) * W_W'(nmul_x);
         end
         wsve_pkg::ST_NUM2: begin
            neg_ff <= diff[D_W-1];
            mag_ff <= diff_abs[wsve_pkg::MAG_W-1:0];
            m_ff   <= '0;
            c_ff   <= '0;
         end
         wsve_pkg::ST_SCLM: begin
            prod_ff <= P_W'(mul_a) * P_W'(mul_b);
         end
         wsve_pkg::ST_SCLA: begin
            m_ff <= m_ff + (wsve_pkg::M_W'(unsigned'(prod_ff))
                            << (c_ff * wsve_pkg::CHUNK_W));
            c_ff <= c_ff + 1'b1;
         end
         wsve_pkg::ST_DWAIT: begin
            if (div_done) begin
               vel_ff[axis_ff] <= vel_now;
               axis_ff         <= axis_ff + 1'b1;
            end
         end
         default: begin
            j_ff <= j_ff;
         end
      endcase
   end

   // ---------------- divider
   wsve_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (m_ff),
      .divisor  (wsve_pkg::DD_W'(den_ff) << s_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // ---------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == wsve_pkg::ST_EMIT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == wsve_pkg::ST_EMIT && out_free) begin
         rsp_vel_ff[0] <= vel_ff[0];
         rsp_vel_ff[1] <= vel_ff[1];
         rsp_vel_ff[2] <= vel_ff[2];
         rsp_stamp_ff  <= stamp_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vel_x        = rsp_vel_ff[0];
   assign rsp_vel_y        = rsp_vel_ff[1];
   assign rsp_vel_z        = rsp_vel_ff[2];
   assign rsp_out_stamp_ns = rsp_stamp_ff;

endmodule

@@ rtl/core/wsve_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle; top quotient bit flags overflow.
module wsve_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [wsve_pkg::M_W-1:0]        dividend,
   input  logic [wsve_pkg::DD_W-1:0]       divisor,
   output logic                            done,
   output logic [wsve_pkg::Q_W-1:0]        quotient
);

   localparam int DSH_W = wsve_pkg::DD_W + wsve_pkg::Q_W - 1;
   localparam int CN_W  = $clog2(wsve_pkg::Q_W);

   logic                      busy_ff;
   logic                      done_ff;
   logic [CN_W-1:0]           cnt_ff;
   logic [wsve_pkg::M_W-1:0]  rem_ff;
   logic [DSH_W-1:0]          dsh_ff;
   logic [wsve_pkg::Q_W-1:0]  q_ff;
   logic                      fits;

   assign fits = {{(DSH_W - wsve_pkg::M_W){1'b0}}, rem_ff} >= dsh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend;
         dsh_ff <= {divisor, {(wsve_pkg::Q_W - 1){1'b0}}};
         q_ff   <= '0;
         cnt_ff <= CN_W'(wsve_pkg::Q_W - 1);
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= rem_ff - dsh_ff[wsve_pkg::M_W-1:0];
         end
         q_ff   <= {q_ff[wsve_pkg::Q_W-2:0], fits};
         dsh_ff <= dsh_ff >> 1;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

@@ rtl/core/wsve_check.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wsve_check (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [wsve_pkg::VEL_W-1:0]    rsp_vel_x,
   input logic signed [wsve_pkg::VEL_W-1:0]    rsp_vel_y,
   input logic signed [wsve_pkg::VEL_W-1:0]    rsp_vel_z,
   input logic [wsve_pkg::TIME_W-1:0]          rsp_out_stamp_ns
);

   // hold a stalled result beat
   `WSVE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp beat dropped")
   `WSVE_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_vel_x) && $stable(rsp_vel_y) && $stable(rsp_vel_z) && $stable(rsp_out_stamp_ns), "rsp payload changed")
   // one sample at a time: ready drops after each taken beat
   `WSVE_ASSERT_NEXT(a_req_busy, clock, reset, req_valid && req_ready, !req_ready, "req taken twice")
   `WSVE_ASSERT_NEXT(a_no_instant, clock, reset, req_valid && req_ready, !$rose(rsp_valid), "result too early")
   // a new result is loaded only while the input side is busy
   `WSVE_ASSERT(a_rise_busy, clock, reset, $rose(rsp_valid) |-> $past(!req_ready), "result while idle")

endmodule

bind window_slope_velocity_estimator wsve_check u_wsve_check (.*);
